// File: rtl/core/orrl_pkg.sv
// Shared types and constants for the overwriting ring record log.
// Used by every module of the block but orrl_ram; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package orrl_pkg;

   localparam int DEPTH       = 1024;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CAP_W       = ADDR_W + 1;
   localparam int REC_W       = 64;
   localparam int IDX_W       = 10;
   localparam int BURST_W     = 7;
   localparam int MAX_BURST   = 64;
   localparam int HELD_W      = 11;
   localparam int TYPE_W      = 2;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 80;

   typedef enum logic [TYPE_W-1:0] {
      REQ_APPEND  = 2'd0,
      REQ_BURST   = 2'd1,
      REQ_READ_AT = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } ctrl_state_type;

   // Tag that travels alongside one memory read.
   typedef struct packed {
      logic              rec_valid;
      logic              last;
      logic [HELD_W-1:0] held;
   } meta_type;

   // Output buffer status seen by the read sequencer.
   typedef struct packed {
      logic [1:0] occ;
      logic       pop;
   } fill_type;

   typedef struct packed {
      logic [REC_W-1:0] rec;
      meta_type         meta;
   } out_entry_type;

endpackage

`default_nettype wire

// File: rtl/core/orrl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module orrl_ram #(
   parameter int DEPTH_P = 1024,
   parameter int WIDTH_P = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH_P)-1:0] wr_addr,
   input  wire logic [WIDTH_P-1:0]         wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH_P)-1:0] rd_addr,
   output logic      [WIDTH_P-1:0]         rd_data
);

   logic [WIDTH_P-1:0] mem [DEPTH_P];
   logic [WIDTH_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/orrl_ctrl.sv
// Ring pointer keeper and read sequencer: head, count, oldest slot, capacity,
// and the stream of memory reads for a request. Depends on orrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module orrl_ctrl (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire orrl_pkg::req_kind_type               req_kind,
   input  wire logic [orrl_pkg::IDX_W-1:0]           read_index,
   input  wire logic [orrl_pkg::BURST_W-1:0]         burst_len,
   input  wire logic                                 csr_valid,
   input  wire logic [orrl_pkg::CAP_W-1:0]           csr_data,
   input  wire orrl_pkg::fill_type                   fill,
   output logic                                      wr_en,
   output logic [orrl_pkg::ADDR_W-1:0]               wr_addr,
   output logic                                      rd_en,
   output logic [orrl_pkg::ADDR_W-1:0]               rd_addr,
   output logic                                      push_valid,
   output orrl_pkg::meta_type                        push_meta
);

   import orrl_pkg::*;

   ctrl_state_type       state_ff,    state_in;
   logic [ADDR_W-1:0]    head_ff,     head_in;
   logic [CAP_W-1:0]     count_ff,    count_in;
   logic [ADDR_W-1:0]    oldest_ff,   oldest_in;
   logic [CAP_W-1:0]     cap_ff,      cap_in;
   logic [ADDR_W-1:0]    slot_ff,     slot_in;
   logic [BURST_W-1:0]   left_ff,     left_in;
   logic                 rvalid_ff,   rvalid_in;
   logic                 inflight_ff, inflight_in;
   meta_type             meta_ff,     meta_in;

   logic                 accept;
   logic [CAP_W-1:0]     head_inc;
   logic [ADDR_W-1:0]    head_next;
   logic                 full;
   logic [BURST_W-1:0]   bl_sat;
   logic [BURST_W-1:0]   want;
   logic [CAP_W:0]       start_raw;
   logic [ADDR_W-1:0]    start_slot;
   logic [CAP_W:0]       at_raw;
   logic [ADDR_W-1:0]    at_slot;
   logic                 at_valid;
   logic [CAP_W-1:0]     slot_inc;
   logic [2:0]           level;
   logic                 can_issue;
   logic [CAP_W-1:0]     cap_sat;

   always_comb begin
      accept   = req_valid && req_ready;
      head_inc = CAP_W'(head_ff) + CAP_W'(1);
      head_next = (head_inc == cap_ff) ? '0 : head_inc[ADDR_W-1:0];
      full     = (count_ff == cap_ff);

      bl_sat = (burst_len > BURST_W'(MAX_BURST)) ? BURST_W'(MAX_BURST) : burst_len;
      want   = (CAP_W'(bl_sat) > count_ff) ? count_ff[BURST_W-1:0] : bl_sat;

      // First slot of a burst is head minus the number of records to read, modulo capacity.
      start_raw  = (CAP_W+1)'(head_ff) + (CAP_W+1)'(cap_ff) - (CAP_W+1)'(want);
      start_slot = (start_raw >= (CAP_W+1)'(cap_ff))
                   ? ADDR_W'(start_raw - (CAP_W+1)'(cap_ff))
                   : start_raw[ADDR_W-1:0];

      at_valid = (CAP_W'(read_index) < count_ff);
      at_raw   = (CAP_W+1)'(oldest_ff) + (CAP_W+1)'(read_index);
      at_slot  = (at_raw >= (CAP_W+1)'(cap_ff))
                 ? ADDR_W'(at_raw - (CAP_W+1)'(cap_ff))
                 : at_raw[ADDR_W-1:0];

      slot_inc = CAP_W'(slot_ff) + CAP_W'(1);

      // Reserve a buffer place for every read in flight.
      level     = {1'b0, fill.occ} + {2'b00, inflight_ff} - {2'b00, fill.pop};
      can_issue = (state_ff == ST_READ) && (level < 3'd2);

      if (csr_data == '0) begin
         cap_sat = CAP_W'(1);
      end else if (csr_data > CAP_W'(DEPTH)) begin
         cap_sat = CAP_W'(DEPTH);
      end else begin
         cap_sat = csr_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      oldest_in   = oldest_ff;
      cap_in      = cap_ff;
      slot_in     = slot_ff;
      left_in     = left_ff;
      rvalid_in   = rvalid_ff;
      inflight_in = 1'b0;
      meta_in     = meta_ff;
      req_ready   = (state_ff == ST_IDLE);
      wr_en       = 1'b0;
      wr_addr     = head_ff;
      rd_en       = 1'b0;
      rd_addr     = slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  REQ_APPEND: begin
                     wr_en   = 1'b1;
                     head_in = head_next;
                     if (full) begin
                        // When full the oldest record sits at the head.
                        oldest_in = head_next;
                     end else begin
                        count_in = count_ff + CAP_W'(1);
                     end
                  end
                  REQ_BURST: begin
                     if (want != '0) begin
                        state_in  = ST_READ;
                        left_in   = want;
                        slot_in   = start_slot;
                        rvalid_in = 1'b1;
                     end
                  end
                  REQ_READ_AT: begin
                     state_in  = ST_READ;
                     left_in   = BURST_W'(1);
                     slot_in   = at_slot;
                     rvalid_in = at_valid;
                  end
                  REQ_CLEAR: begin
                     head_in   = '0;
                     count_in  = '0;
                     oldest_in = '0;
                  end
                  default: begin
                     head_in = head_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (can_issue) begin
               rd_en          = 1'b1;
               inflight_in    = 1'b1;
               meta_in.rec_valid = rvalid_ff;
               meta_in.last   = (left_ff == BURST_W'(1));
               meta_in.held   = count_ff;
               slot_in        = (slot_inc == cap_ff) ? '0 : slot_inc[ADDR_W-1:0];
               left_in        = left_ff - BURST_W'(1);
               if (left_ff == BURST_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         cap_in    = cap_sat;
         head_in   = '0;
         count_in  = '0;
         oldest_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         oldest_ff   <= '0;
         cap_ff      <= CAP_W'(DEPTH);
         left_ff     <= '0;
         inflight_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         oldest_ff   <= oldest_in;
         cap_ff      <= cap_in;
         left_ff     <= left_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      rvalid_ff <= rvalid_in;
      meta_ff   <= meta_in;
   end

   assign push_valid = inflight_ff;
   assign push_meta  = meta_ff;

endmodule

`default_nettype wire

// File: rtl/core/orrl_obuf.sv
// Two-word result buffer between the record memory and the result channel.
// Depends on orrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module orrl_obuf (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_valid,
   input  wire orrl_pkg::meta_type            push_meta,
   input  wire logic [orrl_pkg::REC_W-1:0]    push_rec,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output orrl_pkg::out_entry_type            out_entry,
   output orrl_pkg::fill_type                 fill
);

   import orrl_pkg::*;

   out_entry_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    occ_ff,    occ_in;
   logic          pop;
   out_entry_type new_entry;

   always_comb begin
      pop       = out_valid && out_ready;
      // A lookup past the stored records reads as zero.
      new_entry.rec  = push_meta.rec_valid ? push_rec : '0;
      new_entry.meta = push_meta;
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      occ_in    = occ_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign out_valid = (occ_ff != '0);
   assign out_entry = entry_ff[rd_ptr_ff];
   assign fill      = '{occ: occ_ff, pop: pop};

endmodule

`default_nettype wire

// File: rtl/core/overwriting_ring_record_log_core.sv
// Top level of the overwriting ring record log: record memory, ring sequencer
// and result buffer. Depends on orrl_pkg, orrl_ram, orrl_ctrl and orrl_obuf.
`timescale 1ns / 1ps
`default_nettype none

// The log keeps up to 1024 records of 64 bits in one single-port-read RAM.
// Appends and clears are taken one per cycle while no read is in progress, and
// give no result word. A read-newest request of n records (n = min(held,
// burst_len, 64)) starts the sequencer, which issues one memory read per cycle
// while the result buffer has room; the next request is taken once the last
// read is issued. A read-at request issues a single read. Result words pass
// through the memory read register and a two-word buffer, so a stalled
// result side only pauses the memory reads. The one read port of the record
// memory sets the rate of one result word per cycle. Writing the capacity
// register empties the log; the store needs no clearing pass, as only slots
// written since the last empty are ever read.
module overwriting_ring_record_log_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [63:0] record_in, [73:64] read_index, [80:74] burst_len, [87:81] zero
   input  wire logic [orrl_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] req_type
   input  wire logic [orrl_pkg::TYPE_W-1:0]         req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [63:0] record_out, [74:64] entries_held, [79:75] zero
   output logic [orrl_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // [0] record_valid
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [orrl_pkg::CAP_W-1:0]          csr_data
);

   import orrl_pkg::*;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [REC_W-1:0]     rd_data;
   logic                 push_valid;
   meta_type             push_meta;
   fill_type             fill;
   out_entry_type        out_entry;
   req_kind_type         req_kind;

   assign req_kind  = req_kind_type'(req_tuser);
   assign csr_ready = 1'b1;

   orrl_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (REC_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[REC_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   orrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_kind),
      .read_index (req_tdata[REC_W +: IDX_W]),
      .burst_len  (req_tdata[REC_W+IDX_W +: BURST_W]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .fill       (fill),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .push_valid (push_valid),
      .push_meta  (push_meta)
   );

   orrl_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_meta  (push_meta),
      .push_rec   (rd_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_entry  (out_entry),
      .fill       (fill)
   );

   assign rsp_tdata = {(RSP_DATA_W-REC_W-HELD_W)'(0), out_entry.meta.held, out_entry.rec};
   assign rsp_tuser = out_entry.meta.rec_valid;
   assign rsp_tlast = out_entry.meta.last;

`ifndef ASSERT_OFF
   // A word arriving from memory must always find a free buffer place.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_valid && (fill.occ == 2'd2)) |-> fill.pop)
      else $error("result buffer overflow");

   // No memory read is issued while a new request can be taken.
   a_read_vs_accept: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !req_tready)
      else $error("memory read while request port is open");

   // A memory write only happens for a request that is taken.
   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (req_tvalid && req_tready))
      else $error("memory write without a taken request");

   // A result that holds no stored record carries zero data.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[REC_W-1:0] == '0))
      else $error("invalid result with nonzero data");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking bench for overwriting_ring_record_log_core: appends, burst reads,
// indexed reads, clears and capacity writes, checked against an in-bench ring model.
// Depends on orrl_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
   import orrl_pkg::*;

   typedef struct {
      req_kind_type       kind;
      logic [REC_W-1:0]   rec;
      logic [IDX_W-1:0]   idx;
      logic [BURST_W-1:0] burst;
   } log_req_type;

   typedef struct {
      logic [REC_W-1:0]  rec;
      logic              ok;
      logic              last;
      logic [HELD_W-1:0] held;
   } log_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [TYPE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CAP_W-1:0]      csr_data = '0;

   // Ring model of the log.
   logic [REC_W-1:0] log_mem [DEPTH];
   int               log_head = 0;
   int               log_count = 0;
   int               log_cap = DEPTH;

   log_req_type    req_backlog[$];
   log_result_type due_results[$];
   log_req_type    req_on_bus;
   int             plan_count = 0;
   int             mismatch_count = 0;

   int req_gap_left = 0;
   bit req_gap_on = 1'b0;
   int rsp_stall_left = 0;
   bit rsp_stall_on = 1'b0;
   // A change of the request flag starts one long hold on the result side.
   bit long_hold_req = 1'b0;
   bit long_hold_seen = 1'b0;

   overwriting_ring_record_log_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [REC_W-1:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int ring_slot(input int age);
      return (log_head + log_cap - log_count + age) % log_cap;
   endfunction

   task automatic push_result(input logic [REC_W-1:0] rec, input logic ok, input logic last);
      log_result_type res;
      res.rec  = rec;
      res.ok   = ok;
      res.last = last;
      res.held = log_count[HELD_W-1:0];
      due_results.push_back(res);
   endtask

   task automatic predict_log_request(input log_req_type it);
      int n;
      int i;
      case (it.kind)
         REQ_APPEND: begin
            log_mem[log_head] = it.rec;
            log_head = (log_head + 1) % log_cap;
            if (log_count < log_cap)
               log_count++;
         end
         REQ_BURST: begin
            n = it.burst;
            if (n > MAX_BURST)
               n = MAX_BURST;
            if (n > log_count)
               n = log_count;
            for (i = 0; i < n; i++)
               push_result(log_mem[ring_slot(log_count - n + i)], 1'b1, i == n - 1);
         end
         REQ_READ_AT: begin
            if (it.idx >= log_count)
               push_result('0, 1'b0, 1'b1);
            else
               push_result(log_mem[ring_slot(it.idx)], 1'b1, 1'b1);
         end
         default: begin
            log_head = 0;
            log_count = 0;
         end
      endcase
   endtask

   // Driver: presents queued requests, predicting each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_log_request(req_on_bus);
         if (!req_tvalid || req_tready) begin
            if (req_gap_left > 0) begin
               req_gap_left <= req_gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_on_bus = req_backlog.pop_front();
               req_tuser <= req_on_bus.kind;
               req_tdata <= {7'd0, req_on_bus.burst, req_on_bus.idx, req_on_bus.rec};
               req_tvalid <= 1'b1;
               req_gap_left <= pick_gap(req_gap_on);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side ready, with random stalls and an occasional long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (long_hold_req != long_hold_seen) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= 400;
         long_hold_seen <= long_hold_req;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall_left <= pick_gap(rsp_stall_on);
      end
   end

   // Monitor: every result word is matched against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      log_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result word with nothing expected: rec=%h valid=%b last=%b held=%0d",
                        $realtime, rsp_tdata[REC_W-1:0], rsp_tuser, rsp_tlast,
                        rsp_tdata[REC_W+HELD_W-1:REC_W]);
         end else begin
            want = due_results.pop_front();
            if (rsp_tdata[REC_W-1:0] !== want.rec || rsp_tuser !== want.ok
                || rsp_tlast !== want.last || rsp_tdata[REC_W+HELD_W-1:REC_W] !== want.held) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: expected rec=%h valid=%b last=%b held=%0d, got rec=%h valid=%b last=%b held=%0d",
                           $realtime, want.rec, want.ok, want.last, want.held,
                           rsp_tdata[REC_W-1:0], rsp_tuser, rsp_tlast,
                           rsp_tdata[REC_W+HELD_W-1:REC_W]);
            end
         end
      end
   end

   task automatic queue_req(input req_kind_type kind, input logic [REC_W-1:0] rec,
                            input int idx, input int burst);
      log_req_type it;
      it.kind  = kind;
      it.rec   = rec;
      it.idx   = idx[IDX_W-1:0];
      it.burst = burst[BURST_W-1:0];
      req_backlog.push_back(it);
      if (kind == REQ_APPEND && plan_count < log_cap)
         plan_count++;
      else if (kind == REQ_CLEAR)
         plan_count = 0;
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || due_results.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   // Register writes only happen while the log is idle.
   task automatic write_capacity(input int value);
      int cap;
      csr_valid <= 1'b1;
      csr_data <= value[CAP_W-1:0];
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      cap = value[CAP_W-1:0];
      if (cap == 0)
         cap = 1;
      if (cap > DEPTH)
         cap = DEPTH;
      log_cap = cap;
      log_head = 0;
      log_count = 0;
      plan_count = 0;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_mix(input int n);
      int r;
      int i;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            queue_req(REQ_APPEND, rnd64(), $urandom_range(0, 1023), $urandom_range(0, 127));
         else if (r < 75)
            queue_req(REQ_BURST, rnd64(), $urandom_range(0, 1023),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, MAX_BURST));
         else if (r < 96)
            queue_req(REQ_READ_AT, rnd64(),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                         : $urandom_range(0, (plan_count > 0) ? plan_count : 0),
                      $urandom_range(0, 127));
         else
            queue_req(REQ_CLEAR, rnd64(), $urandom_range(0, 1023), $urandom_range(0, 127));
      end
   endtask

   initial begin
      int k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity: empty reads, clamped bursts, range edges.
      queue_req(REQ_READ_AT, '0, 0, 0);
      queue_req(REQ_BURST, '0, 0, 5);
      queue_req(REQ_APPEND, '1, 1023, 127);
      queue_req(REQ_APPEND, '0, 0, 0);
      queue_req(REQ_APPEND, 64'h0123_4567_89ab_cdef, 0, 0);
      queue_req(REQ_BURST, '1, 1023, 0);
      queue_req(REQ_BURST, '0, 0, 127);
      queue_req(REQ_BURST, '0, 0, 2);
      queue_req(REQ_READ_AT, '0, 0, 0);
      queue_req(REQ_READ_AT, '0, 2, 0);
      queue_req(REQ_READ_AT, '0, 3, 0);
      queue_req(REQ_READ_AT, '1, 1023, 127);
      queue_req(REQ_CLEAR, '1, 1023, 127);
      queue_req(REQ_READ_AT, '0, 0, 0);
      queue_req(REQ_BURST, '0, 0, 64);
      queue_req(REQ_APPEND, 64'ha5a5_a5a5_5a5a_5a5a, 0, 0);
      queue_req(REQ_BURST, '0, 0, 64);
      queue_req(REQ_BURST, '0, 0, 65);
      wait_idle();

      // A written zero means a single slot: every append replaces the last.
      write_capacity(0);
      req_gap_on = 1'b1;
      rsp_stall_on = 1'b1;
      queue_req(REQ_APPEND, 64'h1111_2222_3333_4444, 0, 0);
      queue_req(REQ_APPEND, 64'h5555_6666_7777_8888, 0, 0);
      queue_req(REQ_BURST, '0, 0, 64);
      queue_req(REQ_READ_AT, '0, 0, 0);
      queue_req(REQ_READ_AT, '0, 1, 0);
      queue_random_mix(40);
      wait_idle();

      // Oversized write clamps to full depth.
      write_capacity(2047);
      req_gap_on = 1'b0;
      rsp_stall_on = 1'b0;
      for (k = 0; k < 100; k++) begin
         queue_req(REQ_APPEND, rnd64(), $urandom_range(0, 1023), $urandom_range(0, 127));
         if (k % 40 == 39) begin
            queue_req(REQ_BURST, rnd64(), 0, 64);
            queue_req(REQ_READ_AT, rnd64(), $urandom_range(0, plan_count - 1), 0);
         end
      end
      queue_req(REQ_READ_AT, '0, 0, 0);
      queue_req(REQ_READ_AT, '0, 1023, 0);
      queue_req(REQ_BURST, '0, 0, 127);
      wait_idle();

      write_capacity(2);
      req_gap_on = 1'b1;
      rsp_stall_on = 1'b1;
      queue_random_mix(50);
      wait_idle();

      write_capacity(1025);
      queue_random_mix(50);
      wait_idle();

      write_capacity(17);
      req_gap_on = 1'b0;
      rsp_stall_on = 1'b0;
      queue_random_mix(50);
      wait_idle();

      // Hold the result side off while bursts keep coming, so the input backs up.
      write_capacity(40);
      req_gap_on = 1'b1;
      rsp_stall_on = 1'b1;
      for (k = 0; k < 40; k++)
         queue_req(REQ_APPEND, rnd64(), 0, 0);
      wait_idle();
      long_hold_req <= ~long_hold_req;
      for (k = 0; k < 12; k++) begin
         queue_req(REQ_BURST, rnd64(), 0, $urandom_range(40, 127));
         queue_req(REQ_READ_AT, rnd64(), $urandom_range(0, 50), 0);
      end
      wait_idle();

      write_capacity(3);
      queue_random_mix(40);
      wait_idle();

      write_capacity($urandom_range(1, 2047));
      queue_random_mix(40);
      wait_idle();

      write_capacity(1);
      queue_random_mix(30);
      wait_idle();

      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
